// ===== rtl/bemh_pkg.sv =====
// Package for the bully election message handler.
// Holds the action codes, register indexes, field widths and the evaluation struct.
// No dependencies.
package bemh_pkg;

  localparam int ID_W       = 8;
  localparam int TERM_W     = 63;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_SLOTS  = 8;
  localparam int PEER_SLOTS_DEF = 8;

  typedef enum logic [2:0] {
    ACT_PING        = 3'd0,
    ACT_ELECTION    = 3'd1,
    ACT_COORDINATOR = 3'd2,
    ACT_HEARTBEAT   = 3'd3,
    ACT_FORCE       = 3'd4
  } action_t;

  typedef enum logic {
    REG_OWN_NODE_ID   = 1'b0,
    REG_PEER_ID_SLOTS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic note;        // mark sender in the peer table
    logic follow;      // adopt term and leader
    logic hb_inc;
    logic coord_inc;
    logic request;
    logic reply_own;
    logic reply_term;
  } eval_t;

endpackage

// ===== rtl/bemh_msg_eval.sv =====
// Message evaluation for the bully election message handler.
// Decides the state updates and reply for one inbound message.
// Depends on bemh_pkg.
module bemh_msg_eval (
  input  logic [2:0]                    action,
  input  logic [bemh_pkg::ID_W-1:0]     sender_id,
  input  logic [bemh_pkg::TERM_W-1:0]   message_term,
  input  logic [bemh_pkg::ID_W-1:0]     own_node_id,
  input  logic [bemh_pkg::TERM_W-1:0]   current_term,
  output bemh_pkg::eval_t               eval
);

  logic term_ok;
  logic lower;

  assign term_ok = (message_term >= current_term);
  assign lower   = (sender_id < own_node_id);

  always_comb begin
    eval = '0;
    case (action)
      bemh_pkg::ACT_PING: begin
        eval.reply_own = 1'b1;
      end
      bemh_pkg::ACT_ELECTION: begin
        eval.note      = 1'b1;
        eval.request   = lower;
        eval.reply_own = 1'b1;
      end
      bemh_pkg::ACT_COORDINATOR: begin
        eval.note       = 1'b1;
        eval.follow     = term_ok && (sender_id != own_node_id);
        eval.coord_inc  = eval.follow;
        eval.request    = eval.follow && lower;
        eval.reply_term = 1'b1;
      end
      bemh_pkg::ACT_HEARTBEAT: begin
        eval.note       = 1'b1;
        eval.hb_inc     = 1'b1;
        eval.follow     = term_ok;
        eval.request    = lower;
        eval.reply_term = 1'b1;
      end
      bemh_pkg::ACT_FORCE: begin
        eval.request = 1'b1;
      end
      default: begin
        eval = '0;
      end
    endcase
  end

endmodule

// ===== rtl/bully_election_message_handler.sv =====
// Top level of the bully election message handler (receiver side).
// Input register, evaluation, state update and result register; peer table.
// Depends on bemh_pkg and bemh_msg_eval.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | action, sender_id, message_term, now_time
//  out     | out_valid/out_ready  | reply_value, election_request, follower_role,
//          |                      | known_leader, heartbeat/coordinator_count, ...
//
// One message per cycle while the output does not stall. A message passes the
// input register, then evaluation and state update into the result register.
// The input register takes one more transaction while a result waits, so a
// stalled output backs up to in_ready after two held transactions. Synchronous
// reset clears valids and state, sets own_node_id to 1; cfg writes always taken.
module bully_election_message_handler #(
  parameter int PEER_SLOTS = bemh_pkg::PEER_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [bemh_pkg::CFG_DATA_W-1:0]   cfg_data,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        action,
  input  logic [bemh_pkg::ID_W-1:0]         sender_id,
  input  logic [bemh_pkg::TERM_W-1:0]       message_term,
  input  logic [bemh_pkg::TERM_W-1:0]       now_time,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bemh_pkg::TERM_W-1:0]       reply_value,
  output logic                              election_request,
  output logic                              follower_role,
  output logic [bemh_pkg::ID_W-1:0]         known_leader,
  output logic [bemh_pkg::CNT_W-1:0]        heartbeat_count,
  output logic [bemh_pkg::CNT_W-1:0]        coordinator_count,
  output logic [bemh_pkg::TERM_W-1:0]       heartbeat_time
);

  // configuration
  logic [bemh_pkg::ID_W-1:0]                own_node_id;
  logic [bemh_pkg::CFG_DATA_W-1:0]          peer_id_slots;

  // input register
  logic                                     s1_valid;
  logic [2:0]                               s1_action;
  logic [bemh_pkg::ID_W-1:0]                s1_sender;
  logic [bemh_pkg::TERM_W-1:0]              s1_term;
  logic [bemh_pkg::TERM_W-1:0]              s1_now;

  // state
  logic [bemh_pkg::TERM_W-1:0]              current_term;
  logic [bemh_pkg::ID_W-1:0]                leader_record;
  logic                                     role_flag;
  logic [bemh_pkg::TERM_W-1:0]              last_leader_time;
  logic [bemh_pkg::CNT_W-1:0]               heartbeat_counter;
  logic [bemh_pkg::CNT_W-1:0]               coordinator_counter;
  logic [PEER_SLOTS-1:0]                    peer_reachable;
  logic [bemh_pkg::TERM_W-1:0]              peer_seen_time [PEER_SLOTS];

  // next values
  logic [bemh_pkg::TERM_W-1:0]              current_term_next;
  logic [bemh_pkg::ID_W-1:0]                leader_record_next;
  logic                                     role_flag_next;
  logic [bemh_pkg::TERM_W-1:0]              last_leader_time_next;
  logic [bemh_pkg::CNT_W-1:0]               heartbeat_counter_next;
  logic [bemh_pkg::CNT_W-1:0]               coordinator_counter_next;
  logic [bemh_pkg::TERM_W-1:0]              reply_next;

  bemh_pkg::eval_t                          eval;
  logic                                     advance;
  logic                                     fire;
  logic [PEER_SLOTS-1:0]                    slot_hit;
  logic [PEER_SLOTS-1:0]                    slot_mark;
  logic                                     sender_known;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign fire      = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;

  bemh_msg_eval u_eval (
    .action       (s1_action),
    .sender_id    (s1_sender),
    .message_term (s1_term),
    .own_node_id  (own_node_id),
    .current_term (current_term),
    .eval         (eval)
  );

  // lowest matching peer slot
  assign sender_known = (s1_sender != '0) && (s1_sender != own_node_id);

  always_comb begin
    for (int i = 0; i < PEER_SLOTS; i++) begin
      slot_hit[i] = (peer_id_slots[i*bemh_pkg::ID_W +: bemh_pkg::ID_W] == s1_sender);
    end
  end

  always_comb begin
    logic found;
    found     = 1'b0;
    slot_mark = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      if (slot_hit[i] && !found) begin
        slot_mark[i] = eval.note && sender_known;
        found        = 1'b1;
      end
    end
  end

  always_comb begin
    current_term_next        = current_term;
    leader_record_next       = leader_record;
    role_flag_next           = role_flag;
    last_leader_time_next    = last_leader_time;
    heartbeat_counter_next   = heartbeat_counter;
    coordinator_counter_next = coordinator_counter;
    if (eval.follow) begin
      current_term_next     = s1_term;
      leader_record_next    = s1_sender;
      role_flag_next        = 1'b1;
      last_leader_time_next = s1_now;
    end
    if (eval.hb_inc) begin
      heartbeat_counter_next = heartbeat_counter + 1'b1;
    end
    if (eval.coord_inc) begin
      coordinator_counter_next = coordinator_counter + 1'b1;
    end
    if (eval.reply_own) begin
      reply_next = {{(bemh_pkg::TERM_W - bemh_pkg::ID_W){1'b0}}, own_node_id};
    end else if (eval.reply_term) begin
      reply_next = current_term_next;
    end else begin
      reply_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id   <= bemh_pkg::ID_W'(1);
      peer_id_slots <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bemh_pkg::REG_OWN_NODE_ID:   own_node_id   <= cfg_data[bemh_pkg::ID_W-1:0];
        bemh_pkg::REG_PEER_ID_SLOTS: peer_id_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_sender <= sender_id;
      s1_term   <= message_term;
      s1_now    <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_term        <= '0;
      leader_record       <= '0;
      role_flag           <= 1'b0;
      last_leader_time    <= '0;
      heartbeat_counter   <= '0;
      coordinator_counter <= '0;
      peer_reachable      <= '0;
    end else if (fire) begin
      current_term        <= current_term_next;
      leader_record       <= leader_record_next;
      role_flag           <= role_flag_next;
      last_leader_time    <= last_leader_time_next;
      heartbeat_counter   <= heartbeat_counter_next;
      coordinator_counter <= coordinator_counter_next;
      peer_reachable      <= peer_reachable | slot_mark;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PEER_SLOTS; i++) begin
      if (rst) begin
        peer_seen_time[i] <= '0;
      end else if (fire && slot_mark[i]) begin
        peer_seen_time[i] <= s1_now;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (fire) begin
      reply_value       <= reply_next;
      election_request  <= eval.request;
      follower_role     <= role_flag_next;
      known_leader      <= leader_record_next;
      heartbeat_count   <= heartbeat_counter_next;
      coordinator_count <= coordinator_counter_next;
      heartbeat_time    <= last_leader_time_next;
    end
  end

endmodule
